[rtl/rtam_pkg.sv]
// Shared constants, node record and controller/datapath command types.
`default_nettype none
package rtam_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NODE_COUNT   = 2 * MAX_ELEMENTS;
    localparam int NODE_BITS    = $clog2(NODE_COUNT);
    localparam int SIZE_BITS    = $clog2(MAX_ELEMENTS) + 1;
    localparam int VALUE_BITS   = 64;
    localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS) + 1;
    localparam int SP_BITS      = $clog2(STACK_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        CMD_ASSIGN = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] min_val;
        logic [VALUE_BITS-1:0] add;
        logic [VALUE_BITS-1:0] asg_val;
        logic                  asg_flag;
    } node_rec_t;

    typedef enum logic [2:0] {
        WR_CLEAR   = 3'd0,
        WR_CHILD   = 3'd1,
        WR_PUSHED  = 3'd2,
        WR_TAG_ASG = 3'd3,
        WR_TAG_ADD = 3'd4,
        WR_RECOMP  = 3'd5
    } wr_sel_t;

    typedef struct packed {
        logic                 rd_en;
        logic [NODE_BITS-1:0] rd_addr;
        logic                 cap_x;
        logic                 wr_en;
        logic [NODE_BITS-1:0] wr_addr;
        wr_sel_t              wr_sel;
        logic                 save_a;
        logic                 save_b;
        logic                 acc_init;
        logic                 acc_upd;
        logic                 load_val;
        logic                 out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[rtl/rtam_dp.sv]
// Datapath: node memory, push arithmetic, minimum accumulator and output register.
`default_nettype none
module rtam_dp (
    input  wire                              clk,
    input  wire                              rst_n,
    input  rtam_pkg::dp_cmd_t                dp_cmd,
    input  wire  [rtam_pkg::VALUE_BITS-1:0]  in_value,
    input  wire                              out_stall,
    output logic                             out_valid,
    output logic [rtam_pkg::VALUE_BITS-1:0]  out_data,
    output rtam_pkg::dp_status_t             dp_status
);
    import rtam_pkg::*;

    node_rec_t             mem [NODE_COUNT];
    node_rec_t             rdq_reg;
    node_rec_t             xrec_reg;
    node_rec_t             child_rec;
    node_rec_t             wr_data;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] min_a_reg;
    logic [VALUE_BITS-1:0] min_b_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] out_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] pushed_min;
    logic [VALUE_BITS-1:0] ab_min;
    logic [VALUE_BITS-1:0] acc_min;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_en)
        begin
            mem[dp_cmd.wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en)
        begin
            rdq_reg <= mem[dp_cmd.rd_addr];
        end
    end

    // node value once its own lazy tags are applied
    assign pushed_min = (xrec_reg.asg_flag ? xrec_reg.asg_val : xrec_reg.min_val)
                        + xrec_reg.add;
    assign ab_min  = ($signed(min_b_reg) < $signed(min_a_reg)) ? min_b_reg : min_a_reg;
    assign acc_min = ($signed(pushed_min) < $signed(acc_reg)) ? pushed_min : acc_reg;

    always_comb
    begin
        child_rec = rdq_reg;
        if (xrec_reg.asg_flag)
        begin
            child_rec.asg_val  = xrec_reg.asg_val;
            child_rec.asg_flag = 1'b1;
            child_rec.add      = xrec_reg.add;
        end
        else
        begin
            child_rec.add = rdq_reg.add + xrec_reg.add;
        end
    end

    always_comb
    begin
        wr_data = '{min_val: pushed_min, add: '0, asg_val: xrec_reg.asg_val, asg_flag: 1'b0};
        case (dp_cmd.wr_sel)
            WR_CLEAR:   wr_data = '{min_val: VAL_MAX, add: '0, asg_val: '0, asg_flag: 1'b0};
            WR_CHILD:   wr_data = child_rec;
            WR_PUSHED:  wr_data = '{min_val: pushed_min, add: '0,
                                    asg_val: xrec_reg.asg_val, asg_flag: 1'b0};
            WR_TAG_ASG: wr_data = '{min_val: pushed_min, add: '0,
                                    asg_val: val_reg, asg_flag: 1'b1};
            WR_TAG_ADD: wr_data = '{min_val: pushed_min, add: val_reg,
                                    asg_val: xrec_reg.asg_val, asg_flag: 1'b0};
            WR_RECOMP:  wr_data = '{min_val: ab_min, add: '0, asg_val: '0, asg_flag: 1'b0};
            default:    wr_data = child_rec;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.cap_x)
        begin
            xrec_reg <= rdq_reg;
        end
        if (dp_cmd.load_val)
        begin
            val_reg <= in_value;
        end
        if (dp_cmd.save_a)
        begin
            min_a_reg <= pushed_min;
        end
        if (dp_cmd.save_b)
        begin
            min_b_reg <= pushed_min;
        end
        if (dp_cmd.acc_init)
        begin
            acc_reg <= VAL_MAX;
        end
        else if (dp_cmd.acc_upd)
        begin
            acc_reg <= acc_min;
        end
        if (dp_cmd.out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data           = out_data_reg;
    assign dp_status.out_free = !out_valid_reg || !out_stall;

endmodule
`default_nettype wire

[rtl/rtam_ctrl.sv]
// Controller: tree walk sequencer with explicit frame stack and size register.
`default_nettype none
module rtam_ctrl (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire  [1:0]                      command,
    input  wire  [rtam_pkg::SIZE_BITS-2:0]  range_start,
    input  wire  [rtam_pkg::SIZE_BITS-1:0]  range_end,
    input  wire                             cfg_wr_en,
    input  wire  [rtam_pkg::SIZE_BITS-1:0]  size_in_use,
    output rtam_pkg::dp_cmd_t               dp_cmd,
    input  rtam_pkg::dp_status_t            dp_status
);
    import rtam_pkg::*;

    typedef struct packed {
        logic [NODE_BITS-1:0] x;
        logic [SIZE_BITS-1:0] lx;
        logic [SIZE_BITS-1:0] rx;
    } span_t;

    typedef struct packed {
        span_t span;
        logic  phase;
    } frame_t;

    typedef enum logic [1:0] {
        CTX_ENTRY  = 2'd0,
        CTX_POST_A = 2'd1,
        CTX_POST_B = 2'd2
    } ctx_t;

    typedef enum logic [9:0] {
        S_CLR    = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_PX_RD  = 10'b0000000100,
        S_PX_CAP = 10'b0000001000,
        S_PA_WR  = 10'b0000010000,
        S_PB_WR  = 10'b0000100000,
        S_PX_WR  = 10'b0001000000,
        S_RET    = 10'b0010000000,
        S_RECOMP = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    function automatic span_t left_of(span_t s);
        logic [SIZE_BITS:0] sum;
        span_t              c;
        sum  = {1'b0, s.lx} + {1'b0, s.rx};
        c.x  = s.x + NODE_BITS'(1);
        c.lx = s.lx;
        c.rx = sum[SIZE_BITS:1];
        return c;
    endfunction

    function automatic span_t right_of(span_t s);
        logic [SIZE_BITS:0]   sum;
        logic [SIZE_BITS-1:0] mid;
        logic [SIZE_BITS-1:0] half;
        span_t                c;
        sum  = {1'b0, s.lx} + {1'b0, s.rx};
        mid  = sum[SIZE_BITS:1];
        half = mid - s.lx;
        c.x  = s.x + NODE_BITS'({half, 1'b0});
        c.lx = mid;
        c.rx = s.rx;
        return c;
    endfunction

    state_t               state_reg, state_next;
    ctx_t                 ctx_reg, ctx_next;
    cmd_t                 op_reg, op_next;
    span_t                cur_reg, cur_next;
    span_t                px_reg, px_next;
    logic [SIZE_BITS-1:0] l_reg, l_next;
    logic [SIZE_BITS-1:0] r_reg, r_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [NODE_BITS-1:0] clr_reg, clr_next;
    logic [SP_BITS-1:0]   sp_reg, sp_next;
    frame_t               stack_reg [STACK_DEPTH];
    logic                 stk_wr_en;
    logic [SP_BITS-1:0]   stk_wr_idx;
    frame_t               stk_wr_data;
    logic [SP_BITS-1:0]   top_idx;
    frame_t               top;
    span_t                root;
    logic                 disj;
    logic                 covered;
    logic                 is_leaf;
    logic                 start;

    assign top_idx = sp_reg - SP_BITS'(1);
    assign top     = stack_reg[top_idx];
    assign root    = '{x: '0, lx: '0, rx: size_reg};
    assign disj    = (l_reg >= cur_reg.rx) || (cur_reg.lx >= r_reg);
    assign covered = (cur_reg.lx >= l_reg) && (cur_reg.rx <= r_reg);
    assign is_leaf = (px_reg.rx - px_reg.lx) == SIZE_BITS'(1);
    assign in_stall = (state_reg != S_IDLE);

    // size write is clamped to the legal range
    always_comb
    begin
        size_next = size_reg;
        if (cfg_wr_en)
        begin
            if (size_in_use == '0)
            begin
                size_next = SIZE_BITS'(1);
            end
            else if (size_in_use > SIZE_BITS'(MAX_ELEMENTS))
            begin
                size_next = SIZE_BITS'(MAX_ELEMENTS);
            end
            else
            begin
                size_next = size_in_use;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctx_next    = ctx_reg;
        op_next     = op_reg;
        cur_next    = cur_reg;
        px_next     = px_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        clr_next    = clr_reg;
        sp_next     = sp_reg;
        stk_wr_en   = 1'b0;
        stk_wr_idx  = sp_reg;
        stk_wr_data = '{span: cur_reg, phase: 1'b0};
        start       = 1'b0;
        dp_cmd      = '0;
        dp_cmd.wr_sel = WR_PUSHED;
        case (state_reg)
            S_CLR:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = clr_reg;
                dp_cmd.wr_sel  = WR_CLEAR;
                clr_next       = clr_reg + NODE_BITS'(1);
                if (clr_reg == NODE_BITS'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load_val = 1'b1;
                    l_next = {1'b0, range_start};
                    r_next = range_end;
                    case (command)
                        CMD_ASSIGN:
                        begin
                            op_next = CMD_ASSIGN;
                            start   = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            op_next = CMD_ADD;
                            start   = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            op_next         = CMD_QUERY;
                            dp_cmd.acc_init = 1'b1;
                            start           = 1'b1;
                        end
                        default:
                        begin
                            start = 1'b0;
                        end
                    endcase
                    if (start)
                    begin
                        cur_next   = root;
                        px_next    = root;
                        ctx_next   = CTX_ENTRY;
                        sp_next    = '0;
                        state_next = S_PX_RD;
                    end
                end
            end
            S_PX_RD:
            begin
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_addr = px_reg.x;
                state_next     = S_PX_CAP;
            end
            S_PX_CAP:
            begin
                dp_cmd.cap_x = 1'b1;
                if (is_leaf)
                begin
                    state_next = S_PX_WR;
                end
                else
                begin
                    dp_cmd.rd_en   = 1'b1;
                    dp_cmd.rd_addr = left_of(px_reg).x;
                    state_next     = S_PA_WR;
                end
            end
            S_PA_WR:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = left_of(px_reg).x;
                dp_cmd.wr_sel  = WR_CHILD;
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_addr = right_of(px_reg).x;
                state_next     = S_PB_WR;
            end
            S_PB_WR:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = right_of(px_reg).x;
                dp_cmd.wr_sel  = WR_CHILD;
                state_next     = S_PX_WR;
            end
            S_PX_WR:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = px_reg.x;
                case (ctx_reg)
                    CTX_ENTRY:
                    begin
                        if (disj)
                        begin
                            state_next = S_RET;
                        end
                        else if (covered)
                        begin
                            if (op_reg == CMD_QUERY)
                            begin
                                dp_cmd.acc_upd = 1'b1;
                            end
                            else if (op_reg == CMD_ASSIGN)
                            begin
                                dp_cmd.wr_sel = WR_TAG_ASG;
                            end
                            else
                            begin
                                dp_cmd.wr_sel = WR_TAG_ADD;
                            end
                            state_next = S_RET;
                        end
                        else
                        begin
                            // descend into the left half
                            stk_wr_en   = 1'b1;
                            stk_wr_idx  = sp_reg;
                            stk_wr_data = '{span: cur_reg, phase: 1'b0};
                            sp_next     = sp_reg + SP_BITS'(1);
                            cur_next    = left_of(cur_reg);
                            px_next     = left_of(cur_reg);
                            state_next  = S_PX_RD;
                        end
                    end
                    CTX_POST_A:
                    begin
                        dp_cmd.save_a = 1'b1;
                        px_next       = right_of(cur_reg);
                        ctx_next      = CTX_POST_B;
                        state_next    = S_PX_RD;
                    end
                    CTX_POST_B:
                    begin
                        dp_cmd.save_b = 1'b1;
                        state_next    = S_RECOMP;
                    end
                    default:
                    begin
                        state_next = S_RET;
                    end
                endcase
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = (op_reg == CMD_QUERY) ? S_FIN : S_IDLE;
                end
                else if (!top.phase)
                begin
                    // left half done: go right, frame stays
                    stk_wr_en   = 1'b1;
                    stk_wr_idx  = top_idx;
                    stk_wr_data = '{span: top.span, phase: 1'b1};
                    cur_next    = right_of(top.span);
                    px_next     = right_of(top.span);
                    ctx_next    = CTX_ENTRY;
                    state_next  = S_PX_RD;
                end
                else
                begin
                    sp_next = top_idx;
                    if (op_reg != CMD_QUERY)
                    begin
                        cur_next   = top.span;
                        px_next    = left_of(top.span);
                        ctx_next   = CTX_POST_A;
                        state_next = S_PX_RD;
                    end
                end
            end
            S_RECOMP:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = cur_reg.x;
                dp_cmd.wr_sel  = WR_RECOMP;
                state_next     = S_RET;
            end
            S_FIN:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stack_reg[stk_wr_idx] <= stk_wr_data;
        end
        cur_reg <= cur_next;
        px_reg  <= px_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ctx_reg   <= CTX_ENTRY;
            op_reg    <= CMD_QUERY;
            size_reg  <= SIZE_BITS'(MAX_ELEMENTS);
            clr_reg   <= '0;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            op_reg    <= op_next;
            size_reg  <= size_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
        end
    end

endmodule
`default_nettype wire

[rtl/range_assign_add_min_tree_top.sv]
// Lazy segment tree, range assign / range add / range minimum, 1024 x 64-bit.
// One command at a time. Each node push steps through S_PX_RD, S_PX_CAP, S_PA_WR,
// S_PB_WR and S_PX_WR (S_PX_RD, S_PX_CAP and S_PX_WR at a leaf) on the single node
// memory; up to four nodes per level are visited. A query result is loaded into the
// output register in S_FIN once it is free; the next command is taken while the result
// waits there. After reset a clearing pass writes all 2048 nodes with in_stall high.
`default_nettype none
module range_assign_add_min_tree_top (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire  [1:0]                             command,
    input  wire  [rtam_pkg::SIZE_BITS-2:0]         range_start,
    input  wire  [rtam_pkg::SIZE_BITS-1:0]         range_end,
    input  wire  signed [rtam_pkg::VALUE_BITS-1:0] value,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [rtam_pkg::VALUE_BITS-1:0] min_value,
    input  wire                                    cfg_wr_en,
    input  wire  [rtam_pkg::SIZE_BITS-1:0]         size_in_use
);
    import rtam_pkg::*;

    dp_cmd_t               dp_cmd;
    dp_status_t            dp_status;
    logic [VALUE_BITS-1:0] out_data;

    // sequencer: frame stack walk, clearing pass, transfer handshake on input
    rtam_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .range_start (range_start),
        .range_end   (range_end),
        .cfg_wr_en   (cfg_wr_en),
        .size_in_use (size_in_use),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status)
    );

    // node store and arithmetic; output register parts the result transfer
    rtam_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .in_value  (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .dp_status (dp_status)
    );

    assign min_value = out_data;

    // a memory read and write never share an address in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.rd_en && dp_cmd.wr_en) |-> (dp_cmd.rd_addr != dp_cmd.wr_addr))
        else $error("node memory read and write at same address");

    // while ready for a command, the tree is not being modified
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !dp_cmd.wr_en)
        else $error("node write while accepting commands");

    // a result is only loaded when the output register can take it
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> dp_status.out_free)
        else $error("result overwrites pending output");

    a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule
`default_nettype wire

[tb/range_assign_add_min_tree_top_test.sv]
// Self-checking testbench for the lazy segment tree (assign / add / minimum).
`default_nettype none
module range_assign_add_min_tree_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rtam_pkg::*;

    localparam int NODES      = rtam_pkg::NODE_COUNT;
    localparam int SETTLE     = 800;  // settling wait at the end of a drain, in cycles
    localparam int PHASE_ITEMS = 150;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [SIZE_BITS-2:0] lo;
        logic [SIZE_BITS-1:0] hi;
        val_t                 val;
    } tree_cmd_t;

    localparam val_t SMAX = VAL_MAX;
    localparam val_t SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    wire                  in_stall;
    logic [1:0]           command = '0;
    logic [SIZE_BITS-2:0] range_start = '0;
    logic [SIZE_BITS-1:0] range_end = '0;
    val_t                 value = '0;
    wire                  out_valid;
    logic                 out_stall = 1'b0;
    wire  val_t           min_value;
    logic                 cfg_wr_en = 1'b0;
    logic [SIZE_BITS-1:0] size_in_use = 11'd1024;

    range_assign_add_min_tree_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .range_start(range_start), .range_end(range_end),
        .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .min_value(min_value),
        .cfg_wr_en(cfg_wr_en), .size_in_use(size_in_use)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Shadow tree: same node layout as the block (left x+1, right x+2*half).
    // ---------------------------------------------------------------------
    val_t tree_min   [NODES];
    val_t tree_add   [NODES];
    val_t tree_asg   [NODES];
    bit   tree_asg_on[NODES];
    int   leaves;

    function automatic val_t signed_min(val_t a, val_t b);
        return (b < a) ? b : a;
    endfunction

    // Push lazy tags of node x one level down and fold them into its minimum.
    task automatic push_down(int x, int lx, int rx);
        int m, a, b;
        if (x >= NODES)
            return;
        if (rx - lx > 1)
        begin
            m = (lx + rx) / 2;
            a = x + 1;
            b = x + 2 * (m - lx);
            if (a < NODES && b < NODES)
            begin
                if (tree_asg_on[x])
                begin
                    tree_asg[a] = tree_asg[x];
                    tree_asg[b] = tree_asg[x];
                    tree_asg_on[a] = 1'b1;
                    tree_asg_on[b] = 1'b1;
                    tree_add[a] = '0;
                    tree_add[b] = '0;
                end
                tree_add[a] = tree_add[a] + tree_add[x];
                tree_add[b] = tree_add[b] + tree_add[x];
            end
        end
        if (tree_asg_on[x])
            tree_min[x] = tree_asg[x];
        tree_min[x] = tree_min[x] + tree_add[x];
        tree_add[x] = '0;
        tree_asg_on[x] = 1'b0;
    endtask

    // Range assign / add, walked with an explicit stack instead of recursion.
    task automatic tree_update(bit is_asg, int l, int r, val_t v);
        int sx[64], slx[64], srx[64];
        bit sph[64];
        int sp, t, x, lx, rx, m, a, b;
        sp = 1;
        sx[0] = 0; slx[0] = 0; srx[0] = leaves; sph[0] = 1'b0;
        while (sp > 0)
        begin
            t = sp - 1;
            x = sx[t]; lx = slx[t]; rx = srx[t];
            m = (lx + rx) / 2;
            a = x + 1;
            b = x + 2 * (m - lx);
            if (!sph[t])
            begin
                push_down(x, lx, rx);
                if (x >= NODES || l >= rx || lx >= r)
                    sp--;
                else if (lx >= l && rx <= r)
                begin
                    if (is_asg)
                    begin
                        tree_asg[x] = v;
                        tree_asg_on[x] = 1'b1;
                        tree_add[x] = '0;
                    end
                    else
                        tree_add[x] = tree_add[x] + v;
                    sp--;
                end
                else
                begin
                    sph[t] = 1'b1;
                    sx[sp] = b; slx[sp] = m;  srx[sp] = rx; sph[sp] = 1'b0;
                    sx[sp+1] = a; slx[sp+1] = lx; srx[sp+1] = m; sph[sp+1] = 1'b0;
                    sp += 2;
                end
            end
            else
            begin
                push_down(a, lx, m);
                push_down(b, m, rx);
                if (a < NODES && b < NODES)
                    tree_min[x] = signed_min(tree_min[a], tree_min[b]);
                sp--;
            end
        end
    endtask

    task automatic tree_query(int l, int r, output val_t res);
        int sx[64], slx[64], srx[64];
        int sp, x, lx, rx, m;
        res = SMAX;
        sp = 1;
        sx[0] = 0; slx[0] = 0; srx[0] = leaves;
        while (sp > 0)
        begin
            sp--;
            x = sx[sp]; lx = slx[sp]; rx = srx[sp];
            push_down(x, lx, rx);
            if (x < NODES)
            begin
                if (l <= lx && rx <= r)
                    res = signed_min(res, tree_min[x]);
                else if (!(lx >= r || rx <= l))
                begin
                    m = (lx + rx) / 2;
                    sx[sp] = x + 1;           slx[sp] = lx; srx[sp] = m;
                    sx[sp+1] = x + 2 * (m - lx); slx[sp+1] = m; srx[sp+1] = rx;
                    sp += 2;
                end
            end
        end
    endtask

    function automatic int clamp_size(logic [SIZE_BITS-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_ELEMENTS)
            return MAX_ELEMENTS;
        return int'(s);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: takes pending commands, with a random idle gap after each transfer unless quiet.
    // ---------------------------------------------------------------------
    tree_cmd_t pending_cmds[$];
    val_t      expected_mins[$];
    bit        quiet = 1'b0;    // no idling on either side while set
    int        in_gap = 0;
    int        out_hold = 0;
    int        errors = 0;

    always @(posedge clk)
    begin
        val_t q;
        if (in_valid && !in_stall)
        begin
            case (command)
                CMD_ASSIGN: tree_update(1'b1, range_start, range_end, value);
                CMD_ADD:    tree_update(1'b0, range_start, range_end, value);
                CMD_QUERY:
                begin
                    tree_query(range_start, range_end, q);
                    expected_mins.push_back(q);
                end
                default: ;
            endcase
        end
        if (!in_valid || !in_stall)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                tree_cmd_t c;
                c = pending_cmds.pop_front();
                command     <= c.cmd;
                range_start <= c.lo;
                range_end   <= c.hi;
                value       <= c.val;
                in_valid    <= 1'b1;
                in_gap      <= quiet ? 0 : $urandom_range(0, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest expectation.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        val_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_mins.size() == 0)
            begin
                $display("%0t: unexpected result min_value=%0d", $time, min_value);
                errors++;
            end
            else
            begin
                e = expected_mins.pop_front();
                if (min_value !== e)
                begin
                    $display("%0t: min_value mismatch expected=%0d actual=%0d",
                             $time, e, min_value);
                    errors++;
                end
            end
            out_hold = quiet ? 0 : $urandom_range(0, 5);
        end
        else if (out_hold > 0 && !out_stall)
            ; // hold off until the stall below takes effect
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    function automatic val_t rand_val();
        case ($urandom_range(0, 7))
            0: return SMAX;
            1: return SMIN;
            2: return val_t'($urandom_range(0, 20)) - 10;
            3: return val_t'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic tree_cmd_t rand_cmd(int n);
        tree_cmd_t c;
        int k, lo, hi;
        k = $urandom_range(0, 99);
        if (k < 30)      c.cmd = CMD_ASSIGN;
        else if (k < 55) c.cmd = CMD_ADD;
        else if (k < 97) c.cmd = CMD_QUERY;
        else             c.cmd = CMD_UNUSED;
        k = $urandom_range(0, 19);
        if (k == 0)
        begin
            // noise: anything the ports allow, empty and outside ranges too
            c.lo = (SIZE_BITS-1)'($urandom);
            c.hi = SIZE_BITS'($urandom);
        end
        else
        begin
            lo = $urandom_range(0, n - 1);
            hi = (k < 4) ? lo + 1 : $urandom_range(lo + 1, n);
            if (k == 4)
                hi = $urandom_range(n, 2047);
            c.lo = lo[SIZE_BITS-2:0];
            c.hi = hi[SIZE_BITS-1:0];
        end
        c.val = rand_val();
        return c;
    endfunction

    function automatic tree_cmd_t mk(logic [1:0] cmd, int lo, int hi, val_t v);
        tree_cmd_t c;
        c.cmd = cmd;
        c.lo = lo[SIZE_BITS-2:0];
        c.hi = hi[SIZE_BITS-1:0];
        c.val = v;
        return c;
    endfunction

    // Wait until every command is taken and every result is back, then let
    // any update still walking the tree finish.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_mins.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_size(logic [SIZE_BITS-1:0] s);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        size_in_use <= s;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        leaves = clamp_size(s);
    endtask

    initial
    begin
        logic [SIZE_BITS-1:0] sizes[8];
        for (int i = 0; i < NODES; i++)
        begin
            tree_min[i] = SMAX;
            tree_add[i] = '0;
            tree_asg[i] = '0;
            tree_asg_on[i] = 1'b0;
        end
        leaves = MAX_ELEMENTS;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_size(11'd1024);
        // directed: field extremes, every command, the special cases
        pending_cmds.push_back(mk(CMD_QUERY, 0, 1024, 0));      // untouched tree
        pending_cmds.push_back(mk(CMD_ASSIGN, 0, 1024, SMAX));  // largest value kept
        pending_cmds.push_back(mk(CMD_QUERY, 0, 1024, 0));
        pending_cmds.push_back(mk(CMD_ASSIGN, 1023, 1024, SMIN));
        pending_cmds.push_back(mk(CMD_QUERY, 1023, 1024, 0));
        pending_cmds.push_back(mk(CMD_ADD, 0, 1024, 1));        // wraps at the top
        pending_cmds.push_back(mk(CMD_QUERY, 0, 1024, 0));
        pending_cmds.push_back(mk(CMD_ADD, 0, 512, -1));
        pending_cmds.push_back(mk(CMD_QUERY, 0, 1, 0));
        pending_cmds.push_back(mk(CMD_ASSIGN, 100, 200, 5));    // drops pending adds
        pending_cmds.push_back(mk(CMD_ADD, 150, 300, 7));
        pending_cmds.push_back(mk(CMD_QUERY, 120, 160, 0));
        pending_cmds.push_back(mk(CMD_QUERY, 160, 250, 0));
        pending_cmds.push_back(mk(CMD_QUERY, 300, 300, 0));     // empty range
        pending_cmds.push_back(mk(CMD_QUERY, 500, 400, 0));     // start past end
        pending_cmds.push_back(mk(CMD_ASSIGN, 600, 500, 3));    // no effect
        pending_cmds.push_back(mk(CMD_QUERY, 1000, 2047, 0));   // end past the array
        pending_cmds.push_back(mk(CMD_UNUSED, 0, 1024, 9));     // ignored command
        pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0));
        pending_cmds.push_back(mk(CMD_ADD, 0, 1024, SMIN));
        pending_cmds.push_back(mk(CMD_QUERY, 0, 1024, 0));
        drain();

        // size extremes, out-of-range sizes, and tree reinterpretation on change
        sizes = '{11'd1, 11'd2, 11'd0, 11'd37, 11'd2047, 11'd513, 11'd1024, 11'd3};
        foreach (sizes[p])
        begin
            set_size(sizes[p]);
            quiet = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_cmds.push_back(rand_cmd(leaves));
            drain();
        end

        if (errors == 0)
            $display("PASS range_assign_add_min_tree_top");
        else
            $display("FAIL range_assign_add_min_tree_top");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL range_assign_add_min_tree_top");
        $finish;
    end

endmodule
`default_nettype wire
